// ----- sv/hufd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the Huffman tree builder and decoder.
// No dependencies.
package hufd_pkg;

	localparam int MAX_SYMBOLS = 256;
	localparam int WEIGHT_BITS = 24;
	localparam int NODE_COUNT  = 2 * MAX_SYMBOLS - 1;
	localparam int INNER_COUNT = MAX_SYMBOLS - 1;
	localparam int IDX_W       = 9;
	localparam int NW_W        = 33;

	typedef enum logic [1:0] {
		REQ_LOAD   = 2'd0,
		REQ_BUILD  = 2'd1,
		REQ_CODE   = 2'd2,
		REQ_DECODE = 2'd3
	} req_kind_t;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_CLR  = 7'b0000010,
		ST_SCAN = 7'b0000100,
		ST_WR1  = 7'b0001000,
		ST_WR2  = 7'b0010000,
		ST_CODE = 7'b0100000,
		ST_DEC  = 7'b1000000
	} state_t;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  symbol;
		logic [23:0] weight;
		logic        code_bit;
	} req_t;

	typedef struct packed {
		logic        symbol_valid;
		logic [7:0]  symbol_out;
		logic [63:0] code_bits;
		logic [7:0]  code_length;
		logic        code_too_long;
		logic        tree_ready;
		logic [31:0] total_weight;
	} rsp_t;

	typedef struct packed {
		logic [8:0] count;
		logic       wr;
	} cfg_t;

endpackage

// ----- sv/hufd_ram.sv -----
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
module hufd_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 511,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- sv/hufd_apb.sv -----
`timescale 1ns / 1ps
// APB register slave holding symbol_count.
// Depends on hufd_pkg.
module hufd_apb (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output hufd_pkg::cfg_t    cfg
);
	logic [8:0] count_q;
	logic       hit;

	assign pready = 1'b1;
	assign hit    = psel && penable && pwrite && (paddr[2] == 1'b0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 9'd256;
		end else if (hit) begin
			count_q <= pwdata[8:0];
		end
	end

	assign prdata    = (paddr[2] == 1'b0) ? {23'd0, count_q} : 32'd0;
	assign cfg.count = count_q;
	assign cfg.wr    = hit;
endmodule

// ----- sv/huffman_tree_build_and_decode.sv -----
`timescale 1ns / 1ps
// Top level: request sequencer around the node weight, parent and child RAMs.
// Depends on hufd_pkg, hufd_ram, hufd_apb.
//
// Usage. Program symbol_count over APB (byte address 0) while idle. Issue a
// request by raising start with req; it is taken at an edge where busy is
// low. Each request yields one result beat on rsp, marked by done for one
// cycle; the receiver cannot stall, so every beat must be captured.
// Request sequences:
//   load weight: result in the cycle after acceptance, one load per cycle while busy is low.
//   decode bit : child RAM read of the cursor node, then result and idle again.
//   read code  : parent read of the symbol, then one tree level per cycle,
//                limited by the parent RAM read feeding the next address.
//   build      : m = 2n-1; a parent clear sweep over the m nodes, then every
//                merge k=n..m-1 scans all older nodes through the single
//                weight/parent read port and writes back in ST_WR1 and ST_WR2.
// Requests that find no built tree answer at once with zero fields.
// Reset: symbol_count returns to 256, leaf weights read as zero (per-leaf
// valid bits), the tree is marked unbuilt and the decode cursor cleared.
// No clearing pass is needed after reset; the block is ready at once.
module huffman_tree_build_and_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              start,
	output logic              busy,
	input  hufd_pkg::req_t    req,
	output logic              done,
	output hufd_pkg::rsp_t    rsp
);
	hufd_pkg::cfg_t   cfg;
	hufd_pkg::state_t state_q;

	logic [8:0]  n, root, knn;
	logic [8:0]  k_q, j_q, clr_q, idx_s1, a_q, b_q, c_q, prev_q, cur_q, len_q;
	logic        vld_s1, fa_q, fb_q, pend_q, built_q, bit_q;
	logic [32:0] wa_q, wb_q, root_w_q, w_s1, wsum;
	logic [63:0] code_q, code_nx;
	logic [255:0] wvld_q;
	logic [8:0]  len_nx, p, jdec;
	logic        cont, accept, cbit;

	logic        w_we, p_we, c_we;
	logic [8:0]  w_wa, w_ra, p_wa, p_wd, p_ra;
	logic [32:0] w_wd, w_rd;
	logic [8:0]  p_rd;
	logic [7:0]  c_wa, c_ra;
	logic [17:0] c_wd, c_rd;
	logic [8:0]  nx;
	logic [31:0] total;

	hufd_apb u_apb (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready), .cfg(cfg)
	);

	hufd_ram #(.WIDTH(hufd_pkg::NW_W), .DEPTH(hufd_pkg::NODE_COUNT)) u_wmem (
		.clk(clk), .we(w_we), .waddr(w_wa), .wdata(w_wd), .raddr(w_ra), .rdata(w_rd)
	);
	hufd_ram #(.WIDTH(hufd_pkg::IDX_W), .DEPTH(hufd_pkg::NODE_COUNT)) u_pmem (
		.clk(clk), .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd)
	);
	hufd_ram #(.WIDTH(2 * hufd_pkg::IDX_W), .DEPTH(hufd_pkg::INNER_COUNT)) u_cmem (
		.clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd)
	);

	// Clamp the programmed count into the legal leaf range.
	always_comb begin
		if (cfg.count < 9'd2) n = 9'd2;
		else if (cfg.count > 9'd256) n = 9'd256;
		else n = cfg.count;
	end
	assign root   = 9'((n << 1) - 9'd2);
	assign knn    = 9'(k_q - n);
	assign accept = start && !busy;
	assign busy   = (state_q != hufd_pkg::ST_IDLE);
	assign jdec   = (cur_q < n || cur_q > root) ? root : cur_q;
	assign total  = !built_q ? 32'd0 : (root_w_q[32] ? 32'hFFFF_FFFF : root_w_q[31:0]);

	// Scan candidate: leaves never loaded read as zero.
	assign w_s1 = (idx_s1[8] == 1'b0 && !wvld_q[idx_s1[7:0]]) ? 33'd0 : w_rd;
	assign wsum = wa_q + wb_q;

	// Code walk: fold in the branch bit of the level just read.
	assign p    = p_rd;
	assign cbit = (c_rd[17:9] == prev_q) ? 1'b0 : 1'b1;
	always_comb begin
		code_nx = code_q;
		len_nx  = len_q;
		if (pend_q) begin
			if (len_q < 9'd64) code_nx[len_q[5:0]] = cbit;
			len_nx = 9'(len_q + 9'd1);
		end
	end
	assign cont = (p != 9'd0) && (p >= n) && (p <= root) && (len_nx < 9'd511);
	assign nx   = bit_q ? c_rd[8:0] : c_rd[17:9];

	// RAM port steering.
	always_comb begin
		w_we = 1'b0; w_wa = {1'b0, req.symbol}; w_wd = {9'd0, req.weight};
		p_we = 1'b0; p_wa = clr_q; p_wd = 9'd0;
		c_we = 1'b0; c_wa = knn[7:0]; c_wd = {a_q, b_q};
		w_ra = j_q;  p_ra = j_q;  c_ra = 8'(jdec - n);
		case (state_q)
			hufd_pkg::ST_IDLE: begin
				w_we = accept && (req.req_type == hufd_pkg::REQ_LOAD);
				p_ra = {1'b0, req.symbol};
			end
			hufd_pkg::ST_CLR: p_we = 1'b1;
			hufd_pkg::ST_WR1: begin
				w_we = 1'b1; w_wa = k_q; w_wd = wsum;
				p_we = 1'b1; p_wa = a_q; p_wd = k_q;
				c_we = 1'b1;
			end
			hufd_pkg::ST_WR2: begin
				p_we = 1'b1; p_wa = b_q; p_wd = k_q;
			end
			hufd_pkg::ST_CODE: begin
				p_ra = p; c_ra = 8'(p - n);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hufd_pkg::ST_IDLE;
			built_q <= 1'b0;
			cur_q   <= 9'd0;
			wvld_q  <= '0;
			done    <= 1'b0;
			vld_s1  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (cfg.wr) begin
				built_q <= 1'b0;
				cur_q   <= 9'd0;
			end
			case (state_q)
				hufd_pkg::ST_IDLE: begin
					if (accept) begin
						case (req.req_type)
							hufd_pkg::REQ_LOAD: begin
								wvld_q[req.symbol] <= 1'b1;
								built_q <= 1'b0;
								cur_q   <= 9'd0;
								done    <= 1'b1;
							end
							hufd_pkg::REQ_BUILD: state_q <= hufd_pkg::ST_CLR;
							hufd_pkg::REQ_CODE: begin
								if (built_q && {1'b0, req.symbol} < n) state_q <= hufd_pkg::ST_CODE;
								else done <= 1'b1;
							end
							hufd_pkg::REQ_DECODE: begin
								if (built_q) state_q <= hufd_pkg::ST_DEC;
								else done <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				hufd_pkg::ST_CLR: begin
					// Sweep parent links clear over nodes 0..m-1.
					if (clr_q == root) state_q <= hufd_pkg::ST_SCAN;
				end
				hufd_pkg::ST_SCAN: begin
					vld_s1 <= (j_q < k_q);
					if (j_q == k_q && !vld_s1) state_q <= hufd_pkg::ST_WR1;
				end
				hufd_pkg::ST_WR1: begin
					if (k_q[8] == 1'b0) wvld_q[k_q[7:0]] <= 1'b1;
					state_q <= hufd_pkg::ST_WR2;
				end
				hufd_pkg::ST_WR2: begin
					if (k_q == root) begin
						built_q <= 1'b1;
						cur_q   <= root;
						done    <= 1'b1;
						state_q <= hufd_pkg::ST_IDLE;
					end else begin
						state_q <= hufd_pkg::ST_SCAN;
					end
				end
				hufd_pkg::ST_CODE: begin
					if (!cont) begin
						done    <= 1'b1;
						state_q <= hufd_pkg::ST_IDLE;
					end
				end
				hufd_pkg::ST_DEC: begin
					if (nx < n || nx > root) cur_q <= root;
					else cur_q <= nx;
					done    <= 1'b1;
					state_q <= hufd_pkg::ST_IDLE;
				end
				default: state_q <= hufd_pkg::ST_IDLE;
			endcase
		end
	end

	// Datapath registers; no reset needed.
	always_ff @(posedge clk) begin
		case (state_q)
			hufd_pkg::ST_IDLE: begin
				clr_q  <= 9'd0;
				k_q    <= n;
				j_q    <= 9'd0;
				fa_q   <= 1'b0;
				fb_q   <= 1'b0;
				c_q    <= {1'b0, req.symbol};
				pend_q <= 1'b0;
				len_q  <= 9'd0;
				code_q <= 64'd0;
				bit_q  <= req.code_bit;
			end
			hufd_pkg::ST_CLR: clr_q <= 9'(clr_q + 9'd1);
			hufd_pkg::ST_SCAN: begin
				if (j_q < k_q) j_q <= 9'(j_q + 9'd1);
				idx_s1 <= j_q;
				if (vld_s1 && p_rd == 9'd0) begin
					// Keep the two lightest; earlier index wins a tie.
					if (!fa_q || w_s1 < wa_q) begin
						a_q <= idx_s1; wa_q <= w_s1; fa_q <= 1'b1;
						b_q <= a_q;    wb_q <= wa_q; fb_q <= fa_q;
					end else if (!fb_q || w_s1 < wb_q) begin
						b_q <= idx_s1; wb_q <= w_s1; fb_q <= 1'b1;
					end
				end
			end
			hufd_pkg::ST_WR1: begin
				if (k_q == root) root_w_q <= wsum;
			end
			hufd_pkg::ST_WR2: begin
				k_q  <= 9'(k_q + 9'd1);
				j_q  <= 9'd0;
				fa_q <= 1'b0;
				fb_q <= 1'b0;
			end
			hufd_pkg::ST_CODE: begin
				code_q <= code_nx;
				len_q  <= len_nx;
				prev_q <= c_q;
				c_q    <= p;
				pend_q <= 1'b1;
			end
			default: ;
		endcase
	end

	// Result beat register.
	always_ff @(posedge clk) begin
		rsp.symbol_valid  <= 1'b0;
		rsp.symbol_out    <= 8'd0;
		rsp.code_bits     <= 64'd0;
		rsp.code_length   <= 8'd0;
		rsp.code_too_long <= 1'b0;
		rsp.tree_ready    <= built_q && !(accept && req.req_type == hufd_pkg::REQ_LOAD);
		rsp.total_weight  <= (accept && req.req_type == hufd_pkg::REQ_LOAD) ? 32'd0 : total;
		case (state_q)
			hufd_pkg::ST_WR2: begin
				rsp.tree_ready   <= 1'b1;
				rsp.total_weight <= root_w_q[32] ? 32'hFFFF_FFFF : root_w_q[31:0];
			end
			hufd_pkg::ST_CODE: begin
				rsp.code_bits     <= code_nx;
				rsp.code_length   <= (len_nx > 9'd255) ? 8'd255 : len_nx[7:0];
				rsp.code_too_long <= (len_nx > 9'd64);
			end
			hufd_pkg::ST_DEC: begin
				rsp.symbol_valid <= (nx < n);
				rsp.symbol_out   <= (nx < n) ? nx[7:0] : 8'd0;
			end
			default: ;
		endcase
	end

	a_load_beat: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.req_type == hufd_pkg::REQ_LOAD |=> done)
		else $error("load gave no result beat");
	a_scan_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == hufd_pkg::ST_SCAN |=> !done)
		else $error("result beat during merge scan");
	a_sym_built: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.symbol_valid |-> rsp.tree_ready)
		else $error("symbol decoded without a tree");
	a_long_len: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.code_too_long |-> rsp.code_length > 8'd64)
		else $error("long flag with short length");
endmodule
